// ----- sv/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg: frustum plane culling shared definitions
// Command codes, controller state, the command and status words between
// controller and datapath, and parameter defaults.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int MAX_PLANES_DEF = 8;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS      = 16;

  localparam logic [3:0] PLANE_COUNT_RESET = 4'd6;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_SPHERE = 2'd2;
  localparam logic [1:0] CMD_BOX    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } fpc_state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic deliver;
  } fpc_cmd_t;

  typedef struct packed {
    logic busy;
  } fpc_status_t;

endpackage

// ----- sv/fpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpc_ctrl: frustum plane culling controller
// Holds the plane count register, steps the plane index through the active
// planes, waits for the datapath to drain and hands the result word out.
// ----------------------------------------------------------------------------
module fpc_ctrl
  import fpc_pkg::*;
#(
  parameter  int MAX_PLANES = MAX_PLANES_DEF,
  localparam int CNT_W      = $clog2(MAX_PLANES + 1),
  localparam int SLOT_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data,
  output fpc_cmd_t          cmd,
  output logic [SLOT_W-1:0] idx,
  input  fpc_status_t       status
);

  localparam logic [4:0] MAX_EXT = 5'(MAX_PLANES);

  fpc_state_t       state;
  fpc_state_t       state_next;
  logic [3:0]       plane_count;
  logic [CNT_W-1:0] cnt;
  logic [4:0]       count_ext;
  logic [4:0]       limit_ext;
  logic [CNT_W-1:0] limit;

  assign count_ext = {1'b0, plane_count};
  assign limit_ext = (count_ext > MAX_EXT) ? MAX_EXT : count_ext;
  assign limit     = limit_ext[CNT_W-1:0];
  assign idx       = cnt[SLOT_W-1:0];
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && command != CMD_LOAD) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (cnt == limit) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.accept  = in_valid && (state == ST_IDLE);
    cmd.issue   = (state == ST_ISSUE) && (cnt != limit);
    cmd.deliver = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      plane_count <= PLANE_COUNT_RESET;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) plane_count <= cfg_data;
      if (cmd.accept) begin
        cnt <= '0;
      end else if (cmd.issue) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/fpc_datapath.sv -----
// ----------------------------------------------------------------------------
// fpc_datapath: frustum plane culling datapath
// Plane store, captured object, and a four stage plane pipeline: read,
// multiply, sum of distance and radius, sign test folded into the flag.
// ----------------------------------------------------------------------------
module fpc_datapath
  import fpc_pkg::*;
#(
  parameter  int MAX_PLANES = MAX_PLANES_DEF,
  parameter  int COORD_BITS = COORD_BITS_DEF,
  localparam int SLOT_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1,
  localparam int PROD_W     = 2 * COORD_BITS,
  localparam int CTERM_W    = COORD_BITS + FRAC_BITS,
  localparam int STERM_W    = COORD_BITS - 1 + FRAC_BITS,
  localparam int ACC_W      = 2 * COORD_BITS + 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        command,
  input  logic [2:0]        plane_slot,
  input  logic [31:0]       coord_x,
  input  logic [31:0]       coord_y,
  input  logic [31:0]       coord_z,
  input  logic [31:0]       plane_offset,
  input  logic [30:0]       extent_x,
  input  logic [30:0]       extent_y,
  input  logic [30:0]       extent_z,
  input  fpc_cmd_t          cmd,
  input  logic [SLOT_W-1:0] idx,
  output fpc_status_t       status,
  output logic              visible,
  output logic [1:0]        shape_tested
);

  logic signed [COORD_BITS-1:0] plane_nx [MAX_PLANES];
  logic signed [COORD_BITS-1:0] plane_ny [MAX_PLANES];
  logic signed [COORD_BITS-1:0] plane_nz [MAX_PLANES];
  logic signed [COORD_BITS-1:0] plane_d  [MAX_PLANES];

  logic [4:0] slot_wide;
  logic       slot_ok;

  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic        [COORD_BITS-2:0] ex, ey, ez;
  logic        [1:0]            shape;
  logic                         vis_acc;

  logic                         s0_valid, s1_valid, s2_valid;
  logic signed [COORD_BITS-1:0] rd_nx, rd_ny, rd_nz, rd_d;
  logic        [COORD_BITS-1:0] mag_x, mag_y, mag_z;

  logic signed [PROD_W-1:0]     p_x, p_y, p_z;
  logic        [PROD_W-1:0]     r_x, r_y, r_z;
  logic signed [CTERM_W-1:0]    c_term;
  logic        [STERM_W-1:0]    s_term;

  logic signed [ACC_W-1:0]      dot;
  logic        [ACC_W-1:0]      rad;
  logic signed [ACC_W-1:0]      total;
  logic                         positive;

  assign slot_wide = {2'b00, plane_slot};
  assign slot_ok   = slot_wide < 5'(MAX_PLANES);

  always_ff @(posedge clk) begin
    if (cmd.accept && command == CMD_LOAD && slot_ok) begin
      plane_nx[slot_wide[SLOT_W-1:0]] <= coord_x[COORD_BITS-1:0];
      plane_ny[slot_wide[SLOT_W-1:0]] <= coord_y[COORD_BITS-1:0];
      plane_nz[slot_wide[SLOT_W-1:0]] <= coord_z[COORD_BITS-1:0];
      plane_d[slot_wide[SLOT_W-1:0]]  <= plane_offset[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && command != CMD_LOAD) begin
      cx    <= coord_x[COORD_BITS-1:0];
      cy    <= coord_y[COORD_BITS-1:0];
      cz    <= coord_z[COORD_BITS-1:0];
      ex    <= extent_x[COORD_BITS-2:0];
      ey    <= extent_y[COORD_BITS-2:0];
      ez    <= extent_z[COORD_BITS-2:0];
      shape <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= cmd.issue;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd_nx <= plane_nx[idx];
    rd_ny <= plane_ny[idx];
    rd_nz <= plane_nz[idx];
    rd_d  <= plane_d[idx];
  end

  assign mag_x = rd_nx[COORD_BITS-1] ? (~rd_nx + 1'b1) : rd_nx;
  assign mag_y = rd_ny[COORD_BITS-1] ? (~rd_ny + 1'b1) : rd_ny;
  assign mag_z = rd_nz[COORD_BITS-1] ? (~rd_nz + 1'b1) : rd_nz;

  always_ff @(posedge clk) begin
    p_x    <= rd_nx * cx;
    p_y    <= rd_ny * cy;
    p_z    <= rd_nz * cz;
    c_term <= {rd_d, {FRAC_BITS{1'b0}}};
    if (shape == CMD_BOX) begin
      r_x <= mag_x * ex;
      r_y <= mag_y * ey;
      r_z <= mag_z * ez;
    end else begin
      r_x <= '0;
      r_y <= '0;
      r_z <= '0;
    end
    if (shape == CMD_SPHERE) begin
      s_term <= {ex, {FRAC_BITS{1'b0}}};
    end else begin
      s_term <= '0;
    end
  end

  always_ff @(posedge clk) begin
    dot <= ACC_W'(p_x) + ACC_W'(p_y) + ACC_W'(p_z) + ACC_W'(c_term);
    rad <= ACC_W'(r_x) + ACC_W'(r_y) + ACC_W'(r_z) + ACC_W'(s_term);
  end

  assign total    = dot + signed'(rad);
  assign positive = !total[ACC_W-1] && (total != '0);

  always_ff @(posedge clk) begin
    if (cmd.accept && command != CMD_LOAD) begin
      vis_acc <= 1'b1;
    end else if (s2_valid && !positive) begin
      vis_acc <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      visible      <= vis_acc;
      shape_tested <= shape;
    end
  end

  assign status.busy = s0_valid || s1_valid || s2_valid;

endmodule

// ----- sv/frustum_plane_culling_test.sv -----
// A test word is taken only in the idle state. The active planes are then
// issued one per cycle, the read, multiply and sum stages drain, and the
// result is handed out; the next word is taken only after that. A load
// word is taken in the idle state and does not hold the input.
// Reset: plane count returns to 6, output empty; plane store is not cleared.
// ----------------------------------------------------------------------------
// frustum_plane_culling_test: point, sphere and box culling against planes
// Stores up to MAX_PLANES planes and tests objects against the active ones.
// ----------------------------------------------------------------------------
module frustum_plane_culling_test
  import fpc_pkg::*;
#(
  parameter int MAX_PLANES = MAX_PLANES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [2:0]  plane_slot,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [31:0] plane_offset,
  input  logic [30:0] extent_x,
  input  logic [30:0] extent_y,
  input  logic [30:0] extent_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        visible,
  output logic [1:0]  shape_tested,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int SLOT_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  fpc_cmd_t          cmd;
  fpc_status_t       status;
  logic [SLOT_W-1:0] idx;

  fpc_ctrl #(
    .MAX_PLANES(MAX_PLANES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .idx      (idx),
    .status   (status)
  );

  fpc_datapath #(
    .MAX_PLANES(MAX_PLANES),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .plane_slot  (plane_slot),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .plane_offset(plane_offset),
    .extent_x    (extent_x),
    .extent_y    (extent_y),
    .extent_z    (extent_z),
    .cmd         (cmd),
    .idx         (idx),
    .status      (status),
    .visible     (visible),
    .shape_tested(shape_tested)
  );

endmodule

// ----- sv/fpc_checker.sv -----
// ----------------------------------------------------------------------------
// fpc_checker: port level checks for frustum plane culling
// Watches the top level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module fpc_checker
  import fpc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] command,
  input logic       out_valid,
  input logic       out_ready,
  input logic       visible,
  input logic [1:0] shape_tested
);

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output not empty or input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(shape_tested))
    else $error("stalled result word changed");

  a_shape_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shape_tested != CMD_LOAD)
    else $error("result word carries load code");

  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_LOAD |=> in_ready)
    else $error("load word blocked the input");

  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command != CMD_LOAD |=> !in_ready)
    else $error("input taken while a test is in flight");

endmodule

bind frustum_plane_culling_test fpc_checker u_fpc_checker (.*);

// ----- dv/tb_frustum_plane_culling_test.sv -----
// ----------------------------------------------------------------------------
// tb_frustum_plane_culling_test: self-checking bench for the plane culling block
// Loads culling planes, sweeps the plane count register and streams point,
// sphere and box tests through the block. Each verdict is checked against an
// exact 128-bit dot-product predictor kept in step with every accepted word.
// ----------------------------------------------------------------------------
module tb_frustum_plane_culling_test;
  import fpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] d;
    logic [30:0] ex;
    logic [30:0] ey;
    logic [30:0] ez;
  } cull_word_t;

  typedef struct {
    logic       visible;
    logic [1:0] shape;
  } verdict_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_COMB
  } rx_style_t;

  localparam int ONE   = 32'h0001_0000;
  localparam int DRAIN = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_LOAD;
  logic [2:0]  plane_slot = '0;
  logic [31:0] coord_x = '0;
  logic [31:0] coord_y = '0;
  logic [31:0] coord_z = '0;
  logic [31:0] plane_offset = '0;
  logic [30:0] extent_x = '0;
  logic [30:0] extent_y = '0;
  logic [30:0] extent_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        visible;
  logic [1:0]  shape_tested;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  // predictor state
  logic [31:0] nrm_x [MAX_PLANES_DEF];
  logic [31:0] nrm_y [MAX_PLANES_DEF];
  logic [31:0] nrm_z [MAX_PLANES_DEF];
  logic [31:0] plane_d [MAX_PLANES_DEF];
  logic [3:0]  active_count = PLANE_COUNT_RESET;

  cull_word_t pending_words [$];
  verdict_t   expected_verdicts [$];
  cull_word_t cur_word;

  int words_queued = 0;
  int words_taken = 0;
  int errors = 0;
  int send_gap_max = 4;
  int burst_left = 0;
  int gap_left = 0;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  int rx_cycle = 0;
  rx_style_t rx_style = RX_COIN;
  int n_loads = 0;
  int n_points = 0;
  int n_spheres = 0;
  int n_boxes = 0;
  int n_visible = 0;
  int n_culled = 0;

  frustum_plane_culling_test u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .plane_slot   (plane_slot),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .plane_offset (plane_offset),
    .extent_x     (extent_x),
    .extent_y     (extent_y),
    .extent_z     (extent_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .visible      (visible),
    .shape_tested (shape_tested),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic cull_verdict(cull_word_t w);
    logic signed [127:0] acc, cx, cy, cz, ex, ey, ez, nx, ny, nz, pd;
    int n, i;
    n = (active_count > MAX_PLANES_DEF) ? MAX_PLANES_DEF : int'(active_count);
    cx = $signed(w.x);
    cy = $signed(w.y);
    cz = $signed(w.z);
    ex = w.ex;
    ey = w.ey;
    ez = w.ez;
    for (i = 0; i < n; i++) begin
      nx = $signed(nrm_x[i]);
      ny = $signed(nrm_y[i]);
      nz = $signed(nrm_z[i]);
      pd = $signed(plane_d[i]);
      acc = nx * cx + ny * cy + nz * cz + pd * 65536;
      if (w.cmd == CMD_SPHERE) begin
        acc = acc + ex * 65536;
      end else if (w.cmd == CMD_BOX) begin
        acc = acc + (nx < 0 ? -nx : nx) * ex + (ny < 0 ? -ny : ny) * ey
                  + (nz < 0 ? -nz : nz) * ez;
      end
      if (acc <= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic cull_word_t mk_word(logic [1:0] cmd, logic [2:0] slot,
                                         logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic [31:0] d, logic [30:0] ex,
                                         logic [30:0] ey, logic [30:0] ez);
    cull_word_t w;
    w.cmd = cmd;
    w.slot = slot;
    w.x = x;
    w.y = y;
    w.z = z;
    w.d = d;
    w.ex = ex;
    w.ey = ey;
    w.ez = ez;
    return w;
  endfunction

  function automatic logic [31:0] span(int units);
    return 32'($urandom_range(0, 2 * units)) - 32'(units);
  endfunction

  function automatic cull_word_t random_word();
    cull_word_t w;
    logic wild;
    wild = ($urandom_range(0, 4) == 0);
    w.cmd = ($urandom_range(0, 7) == 0) ? CMD_LOAD : 2'($urandom_range(1, 3));
    w.slot = 3'($urandom_range(0, 7));
    w.x = $urandom();
    w.y = $urandom();
    w.z = $urandom();
    w.d = $urandom();
    w.ex = 31'($urandom());
    w.ey = 31'($urandom());
    w.ez = 31'($urandom());
    if (!wild) begin
      if (w.cmd == CMD_LOAD) begin
        w.x = span(ONE);
        w.y = span(ONE);
        w.z = span(ONE);
        w.d = 32'($urandom_range(0, 40 * ONE)) - 32'(8 * ONE);
      end else begin
        w.x = span(24 * ONE);
        w.y = span(24 * ONE);
        w.z = span(24 * ONE);
        w.ex = 31'($urandom_range(0, 6 * ONE));
        w.ey = 31'($urandom_range(0, 6 * ONE));
        w.ez = 31'($urandom_range(0, 6 * ONE));
      end
    end
    return w;
  endfunction

  task automatic push_word(cull_word_t w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drain();
    while (words_taken != words_queued || expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic set_plane_count(logic [3:0] n);
    wait_drain();
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    active_count = n;
    cfg_valid <= 1'b0;
  endtask

  // sender
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        words_taken++;
        if (cur_word.cmd == CMD_LOAD) begin
          nrm_x[cur_word.slot] = cur_word.x;
          nrm_y[cur_word.slot] = cur_word.y;
          nrm_z[cur_word.slot] = cur_word.z;
          plane_d[cur_word.slot] = cur_word.d;
          n_loads++;
        end else begin
          expected_verdicts.push_back('{visible: cull_verdict(cur_word),
                                        shape: cur_word.cmd});
          case (cur_word.cmd)
            CMD_POINT: n_points++;
            CMD_SPHERE: n_spheres++;
            default: n_boxes++;
          endcase
        end
      end
      if (!in_valid || in_ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          nv = 1'b1;
          command <= cur_word.cmd;
          plane_slot <= cur_word.slot;
          coord_x <= cur_word.x;
          coord_y <= cur_word.y;
          coord_z <= cur_word.z;
          plane_offset <= cur_word.d;
          extent_x <= cur_word.ex;
          extent_y <= cur_word.ey;
          extent_z <= cur_word.ez;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = (send_gap_max > 0) ? $urandom_range(1, send_gap_max) : 0;
          end
        end
        in_valid <= nv;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    logic nr;
    verdict_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (visible) n_visible++;
        else n_culled++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result visible=%0b shape=%0d", $time, visible,
                   shape_tested);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (visible !== want.visible) begin
            $display("%0t: visible mismatch, expected %0b actual %0b", $time,
                     want.visible, visible);
            errors++;
          end
          if (shape_tested !== want.shape) begin
            $display("%0t: shape_tested mismatch, expected %0d actual %0d", $time,
                     want.shape, shape_tested);
            errors++;
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_left = 400;
        rx_hold_req = 1'b0;
      end
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_style = rx_style_t'($urandom_range(0, 2));
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        nr = 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN: nr = 1'b1;
          RX_COIN: nr = 1'($urandom_range(0, 1));
          default: nr = (rx_cycle % 7) < 3;
        endcase
      end
      out_ready <= nr;
    end
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [3:0] sweep [8];
    int k, j;
    sweep = '{4'd3, 4'd8, 4'd15, 4'd0, 4'd1, 4'd6, 4'd9, 4'd5};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // slot 0 is the x = 0 plane, slots 1..6 always pass, slot 7 holds extremes
    push_word(mk_word(CMD_LOAD, 3'd0, ONE, 0, 0, 0, '1, '1, '1));
    for (k = 1; k < 7; k++) push_word(mk_word(CMD_LOAD, 3'(k), 0, 0, 0, ONE, 0, 0, 0));
    push_word(mk_word(CMD_LOAD, 3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h8000_0000, 0, 0, 0));
    push_word(mk_word(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
    push_word(mk_word(CMD_POINT, 0, 1, 0, 0, 0, 0, 0, 0));
    push_word(mk_word(CMD_POINT, 0, 32'hffff_ffff, 0, 0, 0, 0, 0, 0));
    push_word(mk_word(CMD_SPHERE, 0, -ONE, 0, 0, 0, ONE, 0, 0));
    push_word(mk_word(CMD_SPHERE, 0, -ONE, 0, 0, 0, ONE + 1, 0, 0));
    push_word(mk_word(CMD_BOX, 0, -ONE, 0, 0, 0, ONE, '1, '1));
    push_word(mk_word(CMD_BOX, 0, -ONE, 0, 0, 0, ONE + 1, 0, 0));
    push_word(mk_word(CMD_POINT, 3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                      32'hffff_ffff, '1, '1, '1));
    push_word(mk_word(CMD_BOX, 0, 32'h8000_0000, 0, 0, 0, '1, 0, 0));
    set_plane_count(4'd0);
    push_word(mk_word(CMD_POINT, 0, -ONE, 0, 0, 0, 0, 0, 0));
    set_plane_count(4'd15);
    push_word(mk_word(CMD_BOX, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, '1, '1, '1));
    push_word(mk_word(CMD_SPHERE, 0, 0, 0, 0, 0, '1, 0, 0));
    push_word(mk_word(CMD_POINT, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      0, 0, 0, 0));
    set_plane_count(4'd8);
    push_word(mk_word(CMD_BOX, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      0, '1, '1, '1));
    set_plane_count(4'd1);
    push_word(mk_word(CMD_SPHERE, 0, 32'h8000_0000, 0, 0, 0, '1, 0, 0));

    for (k = 0; k < 8; k++) begin
      set_plane_count(sweep[k]);
      send_gap_max = (k % 3 == 1) ? 0 : 2 + 3 * (k % 3);
      for (j = 0; j < 85; j++) push_word(random_word());
      if (k == 1 || k == 4) rx_hold_req = 1'b1;
    end

    wait_drain();
    repeat (30) @(posedge clk);
    $display("Sent %0d plane loads and tested %0d points, %0d spheres, %0d boxes",
             n_loads, n_points, n_spheres, n_boxes);
    $display("Saw %0d visible and %0d culled verdicts across plane counts 0 to 15",
             n_visible, n_culled);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- frustum_plane_culling_test.f -----
sv/fpc_pkg.sv
sv/fpc_ctrl.sv
sv/fpc_datapath.sv
sv/frustum_plane_culling_test.sv
sv/fpc_checker.sv
dv/tb_frustum_plane_culling_test.sv
